FILE: src/lsc_pkg.sv
// Shared constants, tables and controller/datapath interface types for the line sensor centroid.
package lsc_pkg;

    // Sensor bar geometry and sample format.
    localparam int SENSOR_COUNT = 16;
    localparam int SAMPLE_BITS  = 12;
    localparam int IDX_W        = $clog2(SENSOR_COUNT);

    // Noise threshold register format.
    localparam int THR_W = 12;
    localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(409);

    // Position scale and derived arithmetic widths.
    localparam int FULL_SCALE = 1000;
    localparam int POS_W      = $clog2(FULL_SCALE + 1);
    localparam logic [POS_W-1:0] POS_RESET = POS_W'(500);
    localparam int WEIGHT_W   = POS_W;
    localparam int PROD_W     = WEIGHT_W + SAMPLE_BITS;
    localparam int WSUM_W     = PROD_W + IDX_W;
    localparam int RSUM_W     = SAMPLE_BITS + IDX_W;
    localparam int DIV_W      = WSUM_W + POS_W;
    localparam int STEP_W     = $clog2(POS_W);
    localparam int CMP_W      = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);

    // Multiplexer scan order; a longer bar repeats it on the low index bits.
    localparam int CH_W     = 4;
    localparam int SCAN_LEN = 16;
    localparam logic [CH_W-1:0] SCAN_ORDER [SCAN_LEN] = '{
        4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

    // Per-sensor weight table, index * FULL_SCALE / (SENSOR_COUNT - 1), built at elaboration.
    typedef logic [SENSOR_COUNT-1:0][WEIGHT_W-1:0] t_weight_tab;

    function automatic t_weight_tab build_weights();
        t_weight_tab tab;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            tab[i] = WEIGHT_W'((i * FULL_SCALE) / (SENSOR_COUNT - 1));
        end
        return tab;
    endfunction

    localparam t_weight_tab WEIGHTS = build_weights();

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_sample;
        logic mac;
        logic acc;
        logic check;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_end;
        logic rsum_zero;
        logic div_last;
    } t_status;

endpackage

FILE: src/line_sensor_centroid.sv
// Top level of the line sensor centroid: weighted line position over a sensor bar.
// Each sample is taken in idle and passes the multiply, accumulate and check states, then the
// output step; a sample that closes a frame with a nonzero reading sum runs the restoring
// divider between check and output. Only one sample is in work at a time, and a result still
// waiting at the output holds the next sample in its output step and blocks the input.
// Reset is synchronous, active low: sums and sensor index clear, held position 500, threshold 409.
module line_sensor_centroid (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lsc_pkg::THR_W-1:0]         i_cfg_noise_threshold,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lsc_pkg::SAMPLE_BITS-1:0]   i_sample_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lsc_pkg::CH_W-1:0]          o_next_mux_channel,
    output logic [lsc_pkg::POS_W-1:0]         o_line_position,
    output logic                              o_frame_done,
    output logic                              o_no_line
);
    import lsc_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The threshold register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    lsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lsc_datapath u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_status              (status),
        .i_cfg_we              (i_cfg_valid),
        .i_cfg_noise_threshold (i_cfg_noise_threshold),
        .i_sample_value        (i_sample_value),
        .o_next_mux_channel    (o_next_mux_channel),
        .o_line_position       (o_line_position),
        .o_frame_done          (o_frame_done),
        .o_no_line             (o_no_line)
    );

    // A no-line flag only comes with a completed frame.
    a_no_line_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_no_line || o_frame_done))
        else $error("no_line raised without frame_done");

    // The position never leaves its full-scale range.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_line_position <= POS_W'(FULL_SCALE)))
        else $error("line position above full scale");

    // One sample in work at a time: ready drops after a sample transaction.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second sample accepted while one is in work");

endmodule

FILE: src/lsc_datapath.sv
// Datapath: threshold register, weighted accumulation, restoring divider and output register.
module lsc_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lsc_pkg::t_cmd                     i_cmd,
    output lsc_pkg::t_status                  o_status,
    input  logic                              i_cfg_we,
    input  logic [lsc_pkg::THR_W-1:0]         i_cfg_noise_threshold,
    input  logic [lsc_pkg::SAMPLE_BITS-1:0]   i_sample_value,
    output logic [lsc_pkg::CH_W-1:0]          o_next_mux_channel,
    output logic [lsc_pkg::POS_W-1:0]         o_line_position,
    output logic                              o_frame_done,
    output logic                              o_no_line
);
    import lsc_pkg::*;

    logic [THR_W-1:0]       r_thr;
    logic [IDX_W-1:0]       r_index;
    logic [WSUM_W-1:0]      r_wsum;
    logic [RSUM_W-1:0]      r_rsum;
    logic [POS_W-1:0]       r_held;
    logic                   r_frame_end;
    logic                   r_no_line;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [PROD_W-1:0]      r_prod;
    logic [SAMPLE_BITS-1:0] r_hit_sample;
    logic [DIV_W-1:0]       r_rem;
    logic [DIV_W-1:0]       r_dvs;
    logic [STEP_W-1:0]      r_step;
    logic [POS_W-1:0]       r_quot;
    logic [CH_W-1:0]        r_out_ch;
    logic [POS_W-1:0]       r_out_pos;
    logic                   r_out_done;
    logic                   r_out_no_line;

    logic                   hit;
    logic                   div_ge;
    logic [POS_W-1:0]       n_quot;

    // A sample counts only when strictly above the noise threshold.
    assign hit = CMP_W'(r_sample) > CMP_W'(r_thr);

    // One restoring divider step: trial subtract of the shifted divisor.
    assign div_ge = r_rem >= r_dvs;
    assign n_quot = {r_quot[POS_W-2:0], div_ge};

    assign o_status.frame_end = r_frame_end;
    assign o_status.rsum_zero = (r_rsum == '0);
    assign o_status.div_last  = (r_step == '0);

    // Frame state and the threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THRESH_RESET;
            r_index     <= '0;
            r_wsum      <= '0;
            r_rsum      <= '0;
            r_held      <= POS_RESET;
            r_frame_end <= 1'b0;
            r_no_line   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_noise_threshold;
            end
            if (i_cmd.acc) begin
                r_wsum      <= r_wsum + WSUM_W'(r_prod);
                r_rsum      <= r_rsum + RSUM_W'(r_hit_sample);
                r_frame_end <= (r_index == LAST_IDX);
                r_index     <= (r_index == LAST_IDX) ? '0 : r_index + 1'b1;
            end
            if (i_cmd.check) begin
                r_no_line <= r_frame_end && (r_rsum == '0);
            end
            if (i_cmd.div_step && (r_step == '0)) begin
                r_held <= n_quot;
            end
            if (i_cmd.out_load && r_frame_end) begin
                r_wsum <= '0;
                r_rsum <= '0;
            end
        end
    end

    // Sample capture, product, divider and output transaction registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sample <= i_sample_value;
        end
        if (i_cmd.mac) begin
            r_prod       <= hit ? PROD_W'(WEIGHTS[r_index]) * PROD_W'(r_sample) : '0;
            r_hit_sample <= hit ? r_sample : '0;
        end
        if (i_cmd.check) begin
            r_rem  <= DIV_W'(r_wsum);
            r_dvs  <= DIV_W'(r_rsum) << (POS_W - 1);
            r_step <= STEP_W'(POS_W - 1);
            r_quot <= '0;
        end
        if (i_cmd.div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs  <= r_dvs >> 1;
            r_step <= r_step - 1'b1;
            r_quot <= n_quot;
        end
        if (i_cmd.out_load) begin
            r_out_ch      <= SCAN_ORDER[CH_W'(r_index)];
            r_out_pos     <= r_held;
            r_out_done    <= r_frame_end;
            r_out_no_line <= r_no_line;
        end
    end

    assign o_next_mux_channel = r_out_ch;
    assign o_line_position    = r_out_pos;
    assign o_frame_done       = r_out_done;
    assign o_no_line          = r_out_no_line;

endmodule

FILE: src/lsc_ctrl.sv
// Controller: runs accumulation, frame-end division and the output transaction per sample.
module lsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  lsc_pkg::t_status  i_status,
    output lsc_pkg::t_cmd     o_cmd
);
    import lsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_CHK,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    // The output register can take a result when empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    // State and output-valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // The output register fills on a load and empties on a result transaction.
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (i_status.frame_end && !i_status.rsum_zero) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (i_status.div_last) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath commands decoded from the state.
    always_comb begin
        o_cmd             = '0;
        o_cmd.load_sample = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mac         = (r_state == S_MUL);
        o_cmd.acc         = (r_state == S_ACC);
        o_cmd.check       = (r_state == S_CHK);
        o_cmd.div_step    = (r_state == S_DIV);
        o_cmd.out_load    = (r_state == S_OUT) && out_free;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
